>>> hw/rtl/pcgbr_pkg.sv
package pcgbr_pkg;

  localparam logic [63:0] PcgMult = 64'd6364136223846793005;
  localparam int unsigned MaxTries = 16;
  localparam int unsigned TryW = 5;

  localparam logic [0:0] KindDraw = 1'b0;
  localparam logic [0:0] KindSeed = 1'b1;

  localparam logic [0:0] RegStateSeed = 1'b0;
  localparam logic [0:0] RegStreamSeed = 1'b1;

  // Output word of one generator step, taken from the old state.
  function automatic logic [31:0] pcg_output(input logic [63:0] old);
    logic [63:0] x;
    logic [31:0] xs;
    logic [4:0]  rot;
    begin
      x   = (old >> 18) ^ old;
      xs  = x[58:27];
      rot = old[63:59];
      pcg_output = (xs >> rot) | (xs << ((6'd32 - {1'b0, rot}) & 6'd31));
    end
  endfunction

endpackage

>>> hw/rtl/pcgbr_lcg.sv
// One LCG step: state * multiplier + increment, computed with a 16x64
// partial product per cycle (four partial products a step).
module pcgbr_lcg import pcgbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] state_i,
  input  logic [63:0] inc_i,
  output logic        done_o,
  output logic [63:0] state_o
);

  logic [63:0] acc_q, acc_d;
  logic [63:0] src_q, src_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [15:0] mpart;
  logic [79:0] prod;
  logic [63:0] acc_sum;

  always_comb begin
    mpart   = PcgMult[16*cnt_q +: 16];
    prod    = {16'd0, src_q} * {64'd0, mpart};
    acc_sum = acc_q + (prod[63:0] << (16 * cnt_q));
  end

  always_comb begin
    acc_d  = acc_q;
    src_d  = src_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      acc_d  = inc_i;
      src_d  = state_i;
      cnt_d  = 2'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_sum;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    src_q <= src_d;
  end

  // The finished state is valid in the last partial-product cycle, so a new
  // step may be started in that same cycle.
  assign done_o  = busy_q && (cnt_q == 2'd3);
  assign state_o = acc_sum;

endmodule

>>> hw/rtl/pcgbr_mod.sv
// Remainder of a 64-bit dividend by a 33-bit divisor, restoring, one bit per cycle.
module pcgbr_mod (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output logic        done_o,
  output logic [32:0] rem_o
);

  logic [63:0] num_q;
  logic [32:0] rem_q;
  logic [32:0] div_q;
  logic [6:0]  cnt_q;
  logic        busy_q;
  logic [33:0] trial;
  logic [33:0] diff;

  always_comb begin
    trial = {rem_q, num_q[63]};
    diff  = trial - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= 33'd0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      if (!diff[33]) begin
        rem_q <= diff[32:0];
      end else begin
        rem_q <= trial[32:0];
      end
    end
  end

  assign rem_o = rem_q;

endmodule

>>> hw/rtl/pcg32_bounded_random_top.sv
// Channel | Signals                                        | Direction
// in      | in_valid_i/in_ready_o, kind, low/high bound      | request in
// out     | out_valid_o/out_ready_i, value, bad_range        | result out
// cfg     | cfg_valid_i/cfg_ready_o, cfg_index, cfg_data     | register write
// A seed request runs two LCG steps; later seed requests are ignored.
// Reversed or equal bounds are answered straight from idle. Other draws run
// a remainder for the limit, two LCG steps per try, a remainder for the result.
// The bit-serial remainder unit is the slowest part of a draw.
// Reset clears generator state; a result waits in the output register
// while the out channel stalls, and no new request is taken meanwhile.
module pcg32_bounded_random_top import pcgbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [31:0] low_bound_i,
  input  logic [31:0] high_bound_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] value_o,
  output logic        bad_range_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  typedef enum logic [3:0] {
    StIdle, StSeed1, StSeed2, StLimit, StGenHi, StGenLo, StCheck,
    StFinal, StOut
  } state_e;

  state_e      st_q;
  logic [63:0] state_seed_q, stream_seed_q, gen_q, inc_q;
  logic        seeded_q;
  logic [31:0] low_q;
  logic [32:0] range_q, limit_q;
  logic [31:0] hi_q;
  logic [63:0] r_q;
  logic [TryW-1:0] tries_q;
  logic        lcg_start, lcg_done, mod_start, mod_done;
  logic [63:0] lcg_state;
  logic [63:0] mod_dividend;
  logic [32:0] mod_rem;
  logic [32:0] range_c;
  logic [63:0] r_c;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == StIdle);
  assign range_c = {high_bound_i[31], high_bound_i} - {low_bound_i[31], low_bound_i} + 33'd1;
  assign r_c = {hi_q, pcg_output(gen_q)};

  always_comb begin
    lcg_start = 1'b0;
    mod_start = 1'b0;
    mod_dividend = r_q;
    if (st_q == StIdle && in_valid_i && kind_i == KindSeed && !seeded_q) begin
      lcg_start = 1'b1;
    end
    if (st_q == StSeed1 && lcg_done) begin
      lcg_start = 1'b1;
    end
    if (st_q == StIdle && in_valid_i && kind_i == KindDraw &&
        $signed(high_bound_i) > $signed(low_bound_i)) begin
      mod_start = 1'b1;
      mod_dividend = 64'd0 - {31'd0, range_c};
    end
    if (st_q == StLimit && mod_done) begin
      lcg_start = 1'b1;
    end
    if (st_q == StGenHi && lcg_done) begin
      lcg_start = 1'b1;
    end
    if (st_q == StCheck) begin
      if (r_q >= {31'd0, limit_q} || tries_q == TryW'(MaxTries)) begin
        mod_start = 1'b1;
      end else begin
        lcg_start = 1'b1;
      end
    end
  end

  // The low word of a try comes from the state that the high word's step produced.
  pcgbr_lcg u_lcg (
    .clk_i, .rst_ni, .start_i(lcg_start),
    .state_i((st_q == StIdle) ? 64'd0 :
             (st_q == StSeed1) ? lcg_state + state_seed_q :
             (st_q == StGenHi) ? lcg_state : gen_q),
    .inc_i((st_q == StIdle) ? (stream_seed_q | 64'd1) : inc_q),
    .done_o(lcg_done), .state_o(lcg_state)
  );

  pcgbr_mod u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .dividend_i(mod_dividend),
    .divisor_i((st_q == StIdle) ? range_c : range_q),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StIdle;
      state_seed_q  <= 64'd0;
      stream_seed_q <= 64'd0;
      gen_q         <= 64'd0;
      inc_q         <= 64'd0;
      seeded_q      <= 1'b0;
      out_valid_o   <= 1'b0;
      value_o       <= 32'd0;
      bad_range_o   <= 1'b0;
      tries_q       <= '0;
      low_q         <= 32'd0;
      range_q       <= 33'd0;
      limit_q       <= 33'd0;
      hi_q          <= 32'd0;
      r_q           <= 64'd0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegStateSeed:  state_seed_q  <= cfg_data_i;
          RegStreamSeed: stream_seed_q <= cfg_data_i;
          default: ;
        endcase
      end
      case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            low_q   <= low_bound_i;
            range_q <= range_c;
            tries_q <= '0;
            if (kind_i == KindSeed) begin
              if (!seeded_q) begin
                seeded_q <= 1'b1;
                inc_q    <= stream_seed_q | 64'd1;
                st_q     <= StSeed1;
              end
            end else if ($signed(high_bound_i) < $signed(low_bound_i)) begin
              value_o     <= 32'hFFFF_FFFF;
              bad_range_o <= 1'b1;
              out_valid_o <= 1'b1;
              st_q        <= StOut;
            end else if (high_bound_i == low_bound_i) begin
              value_o     <= low_bound_i;
              bad_range_o <= 1'b0;
              out_valid_o <= 1'b1;
              st_q        <= StOut;
            end else begin
              st_q <= StLimit;
            end
          end
        end
        StSeed1: if (lcg_done) st_q <= StSeed2;
        StSeed2: if (lcg_done) begin
          gen_q <= lcg_state;
          st_q  <= StIdle;
        end
        StLimit: if (mod_done) begin
          limit_q <= mod_rem;
          st_q    <= StGenHi;
        end
        StGenHi: if (lcg_done) begin
          hi_q  <= pcg_output(gen_q);
          gen_q <= lcg_state;
          st_q  <= StGenLo;
        end
        StGenLo: if (lcg_done) begin
          r_q     <= r_c;
          gen_q   <= lcg_state;
          tries_q <= tries_q + TryW'(1);
          st_q    <= StCheck;
        end
        StCheck: begin
          if (r_q >= {31'd0, limit_q} || tries_q == TryW'(MaxTries)) begin
            st_q <= StFinal;
          end else begin
            st_q <= StGenHi;
          end
        end
        StFinal: if (mod_done) begin
          value_o     <= low_q + mod_rem[31:0];
          bad_range_o <= 1'b0;
          out_valid_o <= 1'b1;
          st_q        <= StOut;
        end
        StOut: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          st_q        <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

endmodule

>>> hw/rtl/pcgbr_checker.sv
module pcgbr_checker import pcgbr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        kind_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_o,
  input logic        bad_range_o
);

  // A reversed-bounds result always carries all ones.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_range_o |-> value_o == 32'hFFFF_FFFF)
    else $error("bad range without all-ones value");

  // The block never takes a request while a result is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
    else $error("result changed under stall");

  // After a draw request is taken the block is busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KindDraw |=> !in_ready_o)
    else $error("draw request not followed by busy");

endmodule

bind pcg32_bounded_random_top pcgbr_checker u_pcgbr_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .out_valid_o, .out_ready_i,
  .value_o, .bad_range_o
);

>>> tb/sv/pcg32_bounded_random_top_tb.sv
`timescale 1ns / 100ps

module pcg32_bounded_random_top_tb;
  import pcgbr_pkg::*;

  typedef struct packed {
    logic [0:0]  kind;
    logic [31:0] low;
    logic [31:0] high;
  } draw_req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        bad_range;
  } draw_res_t;

  localparam int unsigned StallLimit = 5000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [31:0] low_bound_i;
  logic [31:0] high_bound_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] value_o;
  logic        bad_range_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  pcg32_bounded_random_top uut (.*);

  // Shadow copy of the generator and its seed registers.
  logic [63:0] lcg_state, lcg_inc, seed_word, stream_word;
  logic        is_seeded;

  draw_req_t pending_reqs[$];
  draw_res_t draw_results_q[$];
  logic      in_fire, cfg_fire;
  int        gap_cnt, stall_cnt, idle_cycles, err_cnt;
  int        n_draws, n_reversed, n_equal, n_seeds;
  bit        last_batch;

  function automatic bit calm_phase();
    return last_batch && (pending_reqs.size() < 60);
  endfunction

  function automatic logic [31:0] lcg_word(logic [63:0] old);
    logic [31:0] xs;
    logic [4:0]  rot;
    xs  = 32'(((old >> 18) ^ old) >> 27);
    rot = old[63:59];
    return (xs >> rot) | (xs << (32 - rot));
  endfunction

  task automatic lcg_advance(output logic [31:0] w);
    w         = lcg_word(lcg_state);
    lcg_state = lcg_state * PcgMult + lcg_inc;
  endtask

  task automatic predict_draw(input logic [31:0] lo, input logic [31:0] hi);
    draw_res_t   res;
    logic [32:0] span;
    logic [63:0] rng, lim, r;
    logic [31:0] w1, w2;
    res.bad_range = 1'b0;
    if ($signed(hi) < $signed(lo)) begin
      res.value     = '1;
      res.bad_range = 1'b1;
      n_reversed++;
    end else if (hi == lo) begin
      res.value = lo;
      n_equal++;
    end else begin
      span = {hi[31], hi} - {lo[31], lo} + 33'd1;
      rng  = 64'(span);
      lim  = (64'd0 - rng) % rng;
      r    = '0;
      for (int t = 0; t < MaxTries; t++) begin
        lcg_advance(w1);
        lcg_advance(w2);
        r = {w1, w2};
        if (r >= lim) break;
      end
      res.value = lo + 32'(r % rng);
    end
    draw_results_q.push_back(res);
  endtask

  task automatic seed_generator();
    logic [31:0] w;
    is_seeded = 1'b1;
    lcg_inc   = stream_word | 64'd1;
    lcg_state = '0;
    lcg_advance(w);
    lcg_state = lcg_state + seed_word;
    lcg_advance(w);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sender: one request at a time, idle bursts between requests.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          draw_req_t q;
          q = pending_reqs.pop_front();
          in_valid_i   <= 1'b1;
          kind_i       <= q.kind;
          low_bound_i  <= q.low;
          high_bound_i <= q.high;
          if (!calm_phase() && $urandom_range(0, 5) == 0) gap_cnt = $urandom_range(1, 14);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_cnt > 0) begin
        stall_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm_phase() && $urandom_range(0, 7) == 0) stall_cnt = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin
    in_fire  <= in_valid_i && in_ready_o;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegStateSeed) seed_word = cfg_data_i;
        else stream_word = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        if (kind_i == KindSeed) begin
          n_seeds++;
          if (!is_seeded) seed_generator();
        end else begin
          n_draws++;
          predict_draw(low_bound_i, high_bound_i);
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (draw_results_q.size() == 0) begin
          $error("result with nothing expected: value %h bad_range %b", value_o, bad_range_o);
          err_cnt++;
        end else begin
          draw_res_t e;
          e = draw_results_q.pop_front();
          if (value_o !== e.value) begin
            $error("value: expected %h, got %h", e.value, value_o);
            err_cnt++;
          end
          if (bad_range_o !== e.bad_range) begin
            $error("bad_range: expected %b, got %b", e.bad_range, bad_range_o);
            err_cnt++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= StallLimit) begin
          $display("watchdog: no progress for %0d cycles", StallLimit);
          $display("pcg32_bounded_random_top_tb: errors");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_fire) break;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_reqs.size() > 0 || in_valid_i || draw_results_q.size() > 0);
    // A seed request gives no result and may still be running.
    repeat (20) @(posedge clk_i);
  endtask

  function automatic void add_req(logic [0:0] k, logic [31:0] lo, logic [31:0] hi);
    draw_req_t q;
    q.kind = k;
    q.low  = lo;
    q.high = hi;
    pending_reqs.push_back(q);
  endfunction

  function automatic void add_random_req();
    logic [31:0] a, b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(0, 11))
      0: add_req(KindSeed, a, b);
      1: add_req(KindDraw, a, a);
      2: add_req(KindDraw, 32'h8000_0000, 32'h7FFF_FFFF);
      3: begin
        if ($signed(a) == $signed(b)) b = a - 1;
        if ($signed(a) < $signed(b)) add_req(KindDraw, b, a);
        else add_req(KindDraw, a, b);
      end
      4, 5, 6: begin
        if ($signed(a) > 32'sh7FFF_FFF0) a = 32'h7FFF_FFF0;
        add_req(KindDraw, a, a + $urandom_range(1, 15));
      end
      default: add_req(KindDraw, a, b);
    endcase
  endfunction

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = 1'b0;
    low_bound_i = '0;
    high_bound_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_fire = 1'b0;
    cfg_fire = 1'b0;
    lcg_state = '0;
    lcg_inc = '0;
    seed_word = '0;
    stream_word = '0;
    is_seeded = 1'b0;
    gap_cnt = 0;
    stall_cnt = 0;
    idle_cycles = 0;
    err_cnt = 0;
    n_draws = 0;
    n_reversed = 0;
    n_equal = 0;
    n_seeds = 0;
    last_batch = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(RegStateSeed, '1);
    write_reg(RegStreamSeed, '1);
    write_reg(RegStateSeed, '0);
    write_reg(RegStreamSeed, '0);

    // Draws on the degenerate unseeded generator, bound extremes.
    add_req(KindDraw, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(KindDraw, 32'h0000_0000, 32'h0000_0001);
    add_req(KindDraw, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(KindDraw, 32'h8000_0000, 32'h8000_0000);
    add_req(KindDraw, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_req(KindDraw, 32'hFFFF_FFFB, 32'h0000_0005);
    add_req(KindDraw, 32'h8000_0000, 32'h8000_0002);
    wait_idle();

    write_reg(RegStateSeed, {$urandom, $urandom});
    write_reg(RegStreamSeed, {$urandom, $urandom});
    add_req(KindSeed, '1, '1);
    add_req(KindSeed, '0, '0);
    add_req(KindDraw, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(KindDraw, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    add_req(KindDraw, 32'h8000_0000, 32'h8000_0001);
    add_req(KindDraw, 32'h0000_0000, 32'hFFFF_FFFF);
    add_req(KindDraw, 32'h0000_0001, 32'h0000_0000);
    add_req(KindDraw, 32'h0000_0000, 32'h0000_0002);
    add_req(KindDraw, 32'hC000_0000, 32'h4000_0000);
    add_req(KindDraw, 32'h5555_5555, 32'h5555_5555);
    wait_idle();

    // Register writes after seeding must not disturb the generator.
    write_reg(RegStateSeed, '1);
    write_reg(RegStreamSeed, '0);
    repeat (275) add_random_req();
    wait_idle();

    last_batch = 1'b1;
    repeat (275) add_random_req();
    wait_idle();
    repeat (200) @(posedge clk_i);

    $display("covered %0d draws (%0d reversed, %0d equal bounds) and %0d seed requests",
             n_draws, n_reversed, n_equal, n_seeds);
    if (err_cnt == 0 && draw_results_q.size() == 0) begin
      $display("pcg32_bounded_random_top_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", err_cnt, draw_results_q.size());
      $display("pcg32_bounded_random_top_tb: errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/pcgbr_pkg.sv
hw/rtl/pcgbr_lcg.sv
hw/rtl/pcgbr_mod.sv
hw/rtl/pcg32_bounded_random_top.sv
hw/rtl/pcgbr_checker.sv
tb/sv/pcg32_bounded_random_top_tb.sv
